// ===== design/oaht_pkg.sv =====
//------------------------------------------------------------------------------
// oaht_pkg
// Shared types, constants and codes for the open-addressing key table.
//------------------------------------------------------------------------------
`default_nettype none
package oaht_pkg;

    localparam int unsigned SLOTS_DEFAULT = 1024;
    localparam int unsigned CAP_W         = 11;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned HASH_W        = 32;
    localparam int unsigned CNT_W         = 32;
    localparam int unsigned SLOT_OUT_W    = 10;
    localparam int unsigned OCC_W         = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1021;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // slot marks
    localparam logic [1:0] MARK_UNUSED  = 2'd0;
    localparam logic [1:0] MARK_LIVE    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    // register indexes
    localparam logic [0:0] REG_CAPACITY = 1'd0;
    localparam logic [0:0] REG_PROBING  = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture item, start modulo
        logic mod_step;   // one bit of hash reduction
        logic probe_init; // set probe to home
        logic rd;         // issue slot read
        logic advance;    // next probe offset
        logic coll;       // count a collision
        logic wr_live;    // write key, mark live
        logic wr_del;     // mark deleted
        logic op_inc;     // count op
        logic live_inc;
        logic live_dec;
        logic res_ok;     // latch result ok
        logic res_fail;   // latch result fail
        logic out_load;   // move result into the output register
        logic clr_step;   // clearing sweep step
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic is_live;
        logic is_unused;
        logic key_eq;
        logic probes_done;
        logic half_full;
        logic clr_done;
        logic [1:0] op;
    } stat_t;

endpackage
`default_nettype wire

// ===== design/open_addressing_hash_table.sv =====
//------------------------------------------------------------------------------
// open_addressing_hash_table
// Key table with tombstones, linear or quadratic probing, and counters.
//------------------------------------------------------------------------------
// Sequence: accept, bit-serial hash reduction, probe setup, then per probe a
//   memory read and an evaluate, then a result step; a half-full insert skips probing.
// One item at a time: the next item enters once the last result is loaded.
// Reset: a sweep over every slot clears the slot marks; s_tready stays low.
// Counters and result register clear on reset; configuration resets to 1021/0.
`default_nettype none
module open_addressing_hash_table #(
    parameter int unsigned SLOTS = oaht_pkg::SLOTS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key[31:0], home_hash[63:32]
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // slot_index, occupancy, half_empty,
                                        // op_total, collision_total, zeros
    output logic [1:0]       m_tuser,   // status[1:0]
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [10:0] cfg_wdata
);
    logic [oaht_pkg::CAP_W-1:0] cap_reg;
    logic                       quad_reg;
    oaht_pkg::ctrl_t            ctrl;
    oaht_pkg::stat_t            stat;
    logic [1:0]                 res_status;
    logic [9:0]                 res_slot;
    logic [10:0]                res_occ;
    logic                       res_he;
    logic [31:0]                res_ops, res_colls;
    logic                       s_fire;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= oaht_pkg::CAP_RESET;
            quad_reg <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_addr == oaht_pkg::REG_CAPACITY) cap_reg <= cfg_wdata;
            if (cfg_addr == oaht_pkg::REG_PROBING)  quad_reg <= cfg_wdata[0];
        end
    end

    assign s_fire = s_tvalid && s_tready;

    oaht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_fire  (s_fire),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .ctrl    (ctrl),
        .stat    (stat)
    );

    oaht_datapath #(.SLOTS(SLOTS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .stat           (stat),
        .in_op          (s_tuser),
        .in_key         (s_tdata[31:0]),
        .in_hash        (s_tdata[63:32]),
        .cap_cfg        (cap_reg),
        .quad_cfg       (quad_reg),
        .res_status     (res_status),
        .res_slot       (res_slot),
        .res_occ        (res_occ),
        .res_half_empty (res_he),
        .res_ops        (res_ops),
        .res_colls      (res_colls)
    );

    assign m_tuser = res_status;
    assign m_tdata = {2'd0, res_colls, res_ops, res_he, res_occ, res_slot};

    // no item is taken during the reset sweep
    a_no_accept_in_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready) else $error("accept right after reset");
    // results that do not signal ok always carry slot zero
    a_fail_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != oaht_pkg::ST_OK |-> m_tdata[9:0] == '0)
        else $error("failed result carries a slot");
    // one item in flight: no accept while a probe is running
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second accept");
endmodule
`default_nettype wire

// ===== design/oaht_datapath.sv =====
//------------------------------------------------------------------------------
// oaht_datapath
// Slot memories, hash reduction, probe address generation and counters.
//------------------------------------------------------------------------------
`default_nettype none
module oaht_datapath #(
    parameter int unsigned SLOTS = oaht_pkg::SLOTS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire oaht_pkg::ctrl_t                ctrl,
    output oaht_pkg::stat_t                     stat,
    input  wire logic [1:0]                     in_op,
    input  wire logic [oaht_pkg::KEY_W-1:0]     in_key,
    input  wire logic [oaht_pkg::HASH_W-1:0]    in_hash,
    input  wire logic [oaht_pkg::CAP_W-1:0]     cap_cfg,
    input  wire logic                           quad_cfg,
    output logic [1:0]                          res_status,
    output logic [oaht_pkg::SLOT_OUT_W-1:0]     res_slot,
    output logic [oaht_pkg::OCC_W-1:0]          res_occ,
    output logic                                res_half_empty,
    output logic [oaht_pkg::CNT_W-1:0]          res_ops,
    output logic [oaht_pkg::CNT_W-1:0]          res_colls
);
    localparam int unsigned AW  = $clog2(SLOTS);
    localparam int unsigned CW  = $clog2(SLOTS + 1);
    localparam int unsigned HW  = oaht_pkg::HASH_W;
    localparam int unsigned RW  = CW + 1;             // remainder width
    localparam int unsigned BW  = $clog2(HW);

    logic [oaht_pkg::KEY_W-1:0] slot_keys [SLOTS];
    logic [1:0]                 slot_marks [SLOTS];

    // effective capacity, clamped to 1..SLOTS
    logic [CW-1:0] cap;
    always_comb begin
        priority if (cap_cfg == '0) begin
            cap = CW'(1);
        end else if ({21'd0, cap_cfg} > 32'(SLOTS)) begin
            cap = CW'(SLOTS);
        end else begin
            cap = CW'(cap_cfg);
        end
    end

    logic [1:0]                 op_reg;
    logic [oaht_pkg::KEY_W-1:0] key_reg;
    logic [HW-1:0]              hash_reg;
    logic [RW-1:0]              rem_reg, rem_next;
    logic [BW-1:0]              bit_reg;
    logic                       mod_done_reg;
    logic [AW-1:0]              addr_reg, addr_next;
    logic [CW-1:0]              j_reg;
    logic [CW-1:0]              step_reg, step_next;  // next quadratic increment
    logic [oaht_pkg::KEY_W-1:0] rd_key_reg;
    logic [1:0]                 rd_mark_reg;
    logic [oaht_pkg::OCC_W-1:0] live_reg;
    logic [oaht_pkg::CNT_W-1:0] ops_reg, colls_reg;
    logic [AW:0]                clr_reg;
    logic [1:0]                 st_reg;
    logic [oaht_pkg::SLOT_OUT_W-1:0] slot_reg;

    // restoring modulo, one hash bit per cycle
    always_comb begin
        logic [RW-1:0] sh;
        sh = {rem_reg[RW-2:0], hash_reg[bit_reg]};
        rem_next = (sh >= RW'(cap)) ? sh - RW'(cap) : sh;
    end

    // probe advance: add offset increment, reduce once or twice
    always_comb begin
        logic [CW+1:0] s;
        logic [CW-1:0] inc;
        inc = quad_cfg ? step_reg : CW'(1);
        s = (CW+2)'(addr_reg) + (CW+2)'(inc);
        if (s >= (CW+2)'(cap)) s = s - (CW+2)'(cap);
        if (s >= (CW+2)'(cap)) s = s - (CW+2)'(cap);
        addr_next = AW'(s);
        s = (CW+2)'(step_reg) + (CW+2)'(2);
        if (s >= (CW+2)'(cap)) s = s - (CW+2)'(cap);
        step_next = CW'(s);
    end

    // item capture, modulo and probe state
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            op_reg       <= in_op;
            key_reg      <= in_key;
            hash_reg     <= in_hash;
            rem_reg      <= '0;
            bit_reg      <= BW'(HW - 1);
        end else if (ctrl.mod_step) begin
            rem_reg <= rem_next;
            bit_reg <= bit_reg - BW'(1);
        end
        if (ctrl.probe_init) begin
            addr_reg <= AW'(rem_reg);
            j_reg    <= '0;
            step_reg <= (cap == CW'(1)) ? '0 : CW'(1);
        end else if (ctrl.advance) begin
            addr_reg <= addr_next;
            j_reg    <= j_reg + CW'(1);
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_done_reg <= 1'b0;
        end else if (ctrl.load) begin
            mod_done_reg <= 1'b0;
        end else if (ctrl.mod_step) begin
            mod_done_reg <= (bit_reg == '0);
        end
    end

    // slot memories: registered read, single write port each
    always_ff @(posedge aclk) begin
        if (ctrl.rd) begin
            rd_key_reg <= slot_keys[addr_reg];
        end
        if (ctrl.wr_live) begin
            slot_keys[addr_reg] <= key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd) begin
            rd_mark_reg <= slot_marks[addr_reg];
        end
        if (ctrl.clr_step) begin
            slot_marks[clr_reg[AW-1:0]] <= oaht_pkg::MARK_UNUSED;
        end else if (ctrl.wr_live) begin
            slot_marks[addr_reg] <= oaht_pkg::MARK_LIVE;
        end else if (ctrl.wr_del) begin
            slot_marks[addr_reg] <= oaht_pkg::MARK_DELETED;
        end
    end

    // counters, pending result and clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg   <= '0;
            ops_reg    <= '0;
            colls_reg  <= '0;
            clr_reg    <= '0;
            st_reg     <= oaht_pkg::ST_NOTFOUND;
            slot_reg   <= '0;
        end else begin
            if (ctrl.clr_step) clr_reg <= clr_reg + (AW+1)'(1);
            if (ctrl.coll) colls_reg <= colls_reg + 1'b1;
            if (ctrl.op_inc) ops_reg <= ops_reg + 1'b1;
            if (ctrl.live_inc) live_reg <= live_reg + 1'b1;
            else if (ctrl.live_dec && live_reg != '0) live_reg <= live_reg - 1'b1;
            if (ctrl.res_ok) begin
                st_reg   <= oaht_pkg::ST_OK;
                slot_reg <= oaht_pkg::SLOT_OUT_W'(addr_reg);
            end else if (ctrl.res_fail) begin
                st_reg   <= (op_reg == oaht_pkg::OP_INSERT) ? oaht_pkg::ST_FULL
                                                            : oaht_pkg::ST_NOTFOUND;
                slot_reg <= '0;
            end
        end
    end

    // output register: hold the beat stable while it waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_status     <= oaht_pkg::ST_NOTFOUND;
            res_slot       <= '0;
            res_occ        <= '0;
            res_half_empty <= 1'b1;
            res_ops        <= '0;
            res_colls      <= '0;
        end else if (ctrl.out_load) begin
            res_status     <= st_reg;
            res_slot       <= slot_reg;
            res_occ        <= live_reg;
            res_half_empty <= ({live_reg, 1'b0} <= (oaht_pkg::OCC_W+1)'(cap));
            res_ops        <= ops_reg;
            res_colls      <= colls_reg;
        end
    end

    assign stat.mod_done    = mod_done_reg;
    assign stat.is_live     = (rd_mark_reg == oaht_pkg::MARK_LIVE);
    assign stat.is_unused   = (rd_mark_reg == oaht_pkg::MARK_UNUSED);
    assign stat.key_eq      = (rd_key_reg == key_reg);
    assign stat.probes_done = ((j_reg + CW'(1)) >= cap);
    assign stat.half_full   = ({live_reg, 1'b0} > (oaht_pkg::OCC_W+1)'(cap));
    assign stat.clr_done    = (clr_reg == (AW+1)'(SLOTS));
    assign stat.op          = op_reg;
endmodule
`default_nettype wire

// ===== design/oaht_ctrl.sv =====
//------------------------------------------------------------------------------
// oaht_ctrl
// Sequencer: reset sweep, hash reduction, probe loop and result handshake.
//------------------------------------------------------------------------------
`default_nettype none
module oaht_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_fire,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output oaht_pkg::ctrl_t      ctrl,
    input  wire oaht_pkg::stat_t stat
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MOD   = 8'b0000_0100,
        S_INIT  = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_EVAL  = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    // output register frees once taken; next item may enter while it waits
    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        ctrl       = '0;
        if (m_valid && m_ready) valid_next = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                ctrl.clr_step = 1'b1;
                if (stat.clr_done) begin
                    ctrl.clr_step = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    ctrl.load  = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                ctrl.mod_step = 1'b1;
                if (stat.mod_done) begin
                    ctrl.mod_step = 1'b0;
                    state_next    = S_INIT;
                end
            end
            S_INIT: begin
                ctrl.probe_init = 1'b1;
                priority if (stat.op == oaht_pkg::OP_INSERT && stat.half_full) begin
                    ctrl.probe_init = 1'b0;
                    ctrl.res_fail   = 1'b1;
                    state_next      = S_DONE;
                end else if (stat.op == oaht_pkg::OP_INSERT ||
                             stat.op == oaht_pkg::OP_SEARCH ||
                             stat.op == oaht_pkg::OP_DELETE) begin
                    if (stat.op != oaht_pkg::OP_INSERT) ctrl.op_inc = 1'b1;
                    state_next = S_READ;
                end else begin
                    ctrl.probe_init = 1'b0;
                    ctrl.res_fail   = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_READ: begin
                ctrl.rd    = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (stat.op == oaht_pkg::OP_INSERT) begin
                    if (!stat.is_live) begin
                        ctrl.wr_live  = 1'b1;
                        ctrl.live_inc = 1'b1;
                        ctrl.op_inc   = 1'b1;
                        ctrl.res_ok   = 1'b1;
                        state_next    = S_DONE;
                    end else begin
                        ctrl.coll = 1'b1;
                        if (stat.probes_done) begin
                            ctrl.res_fail = 1'b1;
                            state_next    = S_DONE;
                        end else begin
                            ctrl.advance = 1'b1;
                            state_next   = S_READ;
                        end
                    end
                end else begin
                    priority if (stat.is_live && stat.key_eq) begin
                        ctrl.res_ok = 1'b1;
                        if (stat.op == oaht_pkg::OP_DELETE) begin
                            ctrl.wr_del   = 1'b1;
                            ctrl.live_dec = 1'b1;
                        end
                        state_next = S_DONE;
                    end else if (stat.is_unused) begin
                        ctrl.res_fail = 1'b1;
                        state_next    = S_DONE;
                    end else begin
                        ctrl.coll = 1'b1;
                        if (stat.probes_done) begin
                            ctrl.res_fail = 1'b1;
                            state_next    = S_DONE;
                        end else begin
                            ctrl.advance = 1'b1;
                            state_next   = S_READ;
                        end
                    end
                end
            end
            S_DONE: begin
                // wait for the output register to drain, then load it
                if (!valid_reg || m_ready) begin
                    ctrl.out_load = 1'b1;
                    valid_next    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_OUT: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = valid_reg;
endmodule
`default_nettype wire
